// ===== rtl/pnm_pkg.sv =====
// Package: shared constants, codes and types of the PNM stream decoder.
`default_nettype none
package pnm_pkg;

	// Largest accepted image width or height
	localparam int unsigned MAX_DIM = 16384;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_HEADER    = 3'd2;
	localparam logic [2:0] ERR_PREMATURE = 3'd3;
	localparam logic [2:0] ERR_SAMPLE    = 3'd4;

	// Characters
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Numeric limits
	localparam logic [16:0] NUM_SAT    = 17'd65536;
	localparam logic [16:0] MAXVAL_LIM = 17'd65535;
	localparam logic [16:0] DIM_LIM    = 17'(MAX_DIM);
	localparam logic [15:0] BYTE_MAX   = 16'd255;

	// Sample widths; the pixel count must hold MAX_DIM * MAX_DIM
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned DIM_W    = 15;
	localparam int unsigned COUNT_W  = 29;

endpackage
`default_nettype wire

// ===== rtl/pnm_if.sv =====
// Interfaces: byte input channel and result output channel.
`default_nettype none
interface pnm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pnm_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  fault_code;
	logic [7:0]  red8;
	logic [7:0]  green8;
	logic [7:0]  blue8;
	logic [15:0] red_full;
	logic [15:0] green_full;
	logic [15:0] blue_full;
	logic [14:0] image_width;
	logic [14:0] image_height;
	logic [15:0] sample_max;
	logic        last_pixel;

	modport source (output valid, output kind, output fault_code, output red8, output green8,
		output blue8, output red_full, output green_full, output blue_full, output image_width,
		output image_height, output sample_max, output last_pixel, input ready);
	modport sink (input valid, input kind, input fault_code, input red8, input green8,
		input blue8, input red_full, input green_full, input blue_full, input image_width,
		input image_height, input sample_max, input last_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/pnm_stream_decoder.sv =====
// Top level: streaming P2/P3/P5/P6 image decoder with a shared radix-2 scaling divider.
//
// One file byte is taken per word on the input channel; the block is not ready again until
// that byte is fully handled. Each byte passes through accept, parse and finish steps; a
// byte that both ends a number and must be parsed again gets a second parse step, and on the
// final byte a pending number is closed by parsing a space. A completed pixel then runs each
// of the three channels through one shared restoring divider that forms v*255/maxval one
// quotient bit per cycle (a load step, then one step per quotient bit; a channel at or above
// maxval is set to 255 in its load step). A result waits in an output register; if it has
// not been taken, the next word holds the block in its finish step. After the word marked
// end_of_stream all parser state returns to its reset values, ready for the next file.
`default_nettype none
module pnm_stream_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pnm_byte_if.sink      bytes,
	pnm_result_if.source  results
);
	import pnm_pkg::*;

	// Parser phases
	localparam logic [3:0] PH_MAGIC0   = 4'd0;
	localparam logic [3:0] PH_MAGIC1   = 4'd1;
	localparam logic [3:0] PH_HSKIP    = 4'd2;
	localparam logic [3:0] PH_HCOMMENT = 4'd3;
	localparam logic [3:0] PH_HNUM     = 4'd4;
	localparam logic [3:0] PH_ASKIP    = 4'd5;
	localparam logic [3:0] PH_ANUM     = 4'd6;
	localparam logic [3:0] PH_BDATA    = 4'd7;
	localparam logic [3:0] PH_DONE     = 4'd8;
	localparam logic [3:0] PH_HALT     = 4'd9;

	// Sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PROC   = 3'd1;
	localparam logic [2:0] S_DIV_LD = 3'd2;
	localparam logic [2:0] S_DIV_IT = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] seq_q;
	logic [7:0] cb_q;
	logic       eos_q;
	logic       flush_q;

	// Parser state
	logic [3:0]           phase_q;
	logic [1:0]           fmt_q;
	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [SAMPLE_W-1:0]  maxval_q;
	logic [16:0]          acc_q;
	logic [7:0]           hbyte_q;
	logic [1:0]           ci_q;
	logic [SAMPLE_W-1:0]  ch_q [3];
	logic [COUNT_W-1:0]   left_q;
	logic [1:0]           fsel_q;
	logic                 neg_q;
	logic                 dseen_q;
	logic                 hpend_q;

	// Pending result
	logic       res_v_q;
	logic [1:0] res_kind_q;
	logic [2:0] res_err_q;
	logic       res_last_q;

	// Divider
	logic [1:0]  dch_q;
	logic [2:0]  dcnt_q;
	logic [15:0] rem_q;
	logic [7:0]  dd_q;
	logic [7:0]  quo_q;
	logic [7:0]  s8_q [3];

	// Output register
	logic        out_v_q;
	logic [1:0]  o_kind_q;
	logic [2:0]  o_err_q;
	logic [7:0]  o_s8_q [3];
	logic [15:0] o_full_q [3];
	logic [14:0] o_w_q;
	logic [14:0] o_h_q;
	logic [15:0] o_max_q;
	logic        o_last_q;

	// Next-state values from the byte parser
	logic [3:0]           n_phase;
	logic [1:0]           n_fmt;
	logic [DIM_W-1:0]     n_width;
	logic [DIM_W-1:0]     n_height;
	logic [SAMPLE_W-1:0]  n_maxval;
	logic [16:0]          n_acc;
	logic [7:0]           n_hbyte;
	logic [1:0]           n_ci;
	logic [SAMPLE_W-1:0]  n_ch [3];
	logic [COUNT_W-1:0]   n_left;
	logic [1:0]           n_fsel;
	logic                 n_neg;
	logic                 n_dseen;
	logic                 n_hpend;
	logic                 n_rv;
	logic [1:0]           n_rk;
	logic [2:0]           n_re;
	logic                 n_rlast;
	logic                 rehandle;

	logic                 is_ws;
	logic                 is_dig;
	logic [3:0]           dval;
	logic [20:0]          acc10;
	logic [16:0]          accd;
	logic                 push;
	logic [SAMPLE_W-1:0]  pv;
	logic                 anum_end;
	logic                 err;
	logic [2:0]           ecode;
	logic [2:0]           need;
	logic [16:0]          clampv;

	// Parse one byte against the current parser state
	always_comb begin
		n_phase  = phase_q;
		n_fmt    = fmt_q;
		n_width  = width_q;
		n_height = height_q;
		n_maxval = maxval_q;
		n_acc    = acc_q;
		n_hbyte  = hbyte_q;
		n_ci     = ci_q;
		n_ch     = ch_q;
		n_left   = left_q;
		n_fsel   = fsel_q;
		n_neg    = neg_q;
		n_dseen  = dseen_q;
		n_hpend  = hpend_q;
		n_rv     = res_v_q;
		n_rk     = res_kind_q;
		n_re     = res_err_q;
		n_rlast  = res_last_q;
		rehandle = 1'b0;
		push     = 1'b0;
		pv       = '0;
		anum_end = 1'b0;
		err      = 1'b0;
		ecode    = ERR_NONE;
		clampv   = '0;

		is_ws  = (cb_q == CH_SPACE) || (cb_q >= 8'd9 && cb_q <= 8'd13);
		is_dig = (cb_q >= 8'h30) && (cb_q <= 8'h39);
		dval   = cb_q[3:0];
		acc10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {17'd0, dval};
		accd   = (acc10 > {4'd0, NUM_SAT}) ? NUM_SAT : acc10[16:0];
		need   = fmt_q[0] ? 3'd3 : 3'd1;

		unique case (phase_q)
			PH_MAGIC0: begin
				if (cb_q == CH_P) begin
					n_phase = PH_MAGIC1;
				end else begin
					err = 1'b1;
					ecode = ERR_MAGIC;
				end
			end
			PH_MAGIC1: begin
				n_fsel = 2'd0;
				n_phase = PH_HSKIP;
				unique case (cb_q)
					CH_2: n_fmt = 2'd0;
					CH_3: n_fmt = 2'd1;
					CH_5: n_fmt = 2'd2;
					CH_6: n_fmt = 2'd3;
					default: begin
						err = 1'b1;
						ecode = ERR_MAGIC;
					end
				endcase
			end
			PH_HSKIP: begin
				if (is_ws) begin
					n_phase = PH_HSKIP;
				end else if (cb_q == CH_HASH) begin
					n_phase = PH_HCOMMENT;
				end else if (is_dig) begin
					n_acc = {13'd0, dval};
					n_phase = PH_HNUM;
				end else begin
					err = 1'b1;
					ecode = ERR_HEADER;
				end
			end
			PH_HCOMMENT: begin
				if (cb_q == CH_LF) n_phase = PH_HSKIP;
			end
			PH_HNUM: begin
				if (is_dig) begin
					n_acc = accd;
				end else begin
					n_acc = '0;
					if (fsel_q < 2'd2) begin
						if (acc_q == '0 || acc_q > DIM_LIM) begin
							err = 1'b1;
							ecode = ERR_HEADER;
						end else begin
							if (fsel_q == 2'd0) n_width = acc_q[DIM_W-1:0];
							else n_height = acc_q[DIM_W-1:0];
							n_fsel = fsel_q + 2'd1;
							n_phase = PH_HSKIP;
							rehandle = 1'b1;
						end
					end else if (acc_q == '0 || acc_q > MAXVAL_LIM) begin
						err = 1'b1;
						ecode = ERR_HEADER;
					end else begin
						n_maxval = acc_q[15:0];
						n_left = COUNT_W'(width_q) * COUNT_W'(height_q);
						n_ci = 2'd0;
						n_hpend = 1'b0;
						if (!fmt_q[1] && !is_ws) begin
							err = 1'b1;
							ecode = ERR_HEADER;
						end else begin
							n_phase = fmt_q[1] ? PH_BDATA : PH_ASKIP;
							n_rv = 1'b1;
							n_rk = KIND_HEADER;
							n_re = ERR_NONE;
							n_rlast = 1'b0;
						end
					end
				end
			end
			PH_ASKIP: begin
				if (is_ws) begin
					n_phase = PH_ASKIP;
				end else if (is_dig) begin
					n_acc = {13'd0, dval};
					n_neg = 1'b0;
					n_dseen = 1'b1;
					n_phase = PH_ANUM;
				end else if (cb_q == CH_MINUS || cb_q == CH_PLUS) begin
					n_acc = '0;
					n_neg = (cb_q == CH_MINUS);
					n_dseen = 1'b0;
					n_phase = PH_ANUM;
				end else begin
					err = 1'b1;
					ecode = ERR_SAMPLE;
				end
			end
			PH_ANUM: begin
				if (is_dig) begin
					n_acc = accd;
					n_dseen = 1'b1;
				end else if (!dseen_q) begin
					err = 1'b1;
					ecode = ERR_SAMPLE;
				end else begin
					clampv = neg_q ? 17'd0 : acc_q;
					if (clampv > {1'b0, maxval_q}) clampv = {1'b0, maxval_q};
					pv = clampv[15:0];
					n_acc = '0;
					n_phase = PH_ASKIP;
					push = 1'b1;
					anum_end = 1'b1;
				end
			end
			PH_BDATA: begin
				if (maxval_q > BYTE_MAX) begin
					if (!hpend_q) begin
						n_hbyte = cb_q;
						n_hpend = 1'b1;
					end else begin
						n_hpend = 1'b0;
						pv = {hbyte_q, cb_q};
						push = 1'b1;
					end
				end else begin
					pv = {8'd0, cb_q};
					push = 1'b1;
				end
			end
			default: begin
				n_phase = phase_q;
			end
		endcase

		// Store a sample; close the pixel when all channels are in
		if (push) begin
			n_ch[ci_q] = pv;
			if ({1'b0, ci_q} + 3'd1 < need) begin
				n_ci = ci_q + 2'd1;
			end else begin
				n_ci = 2'd0;
				if (!fmt_q[0]) begin
					n_ch[1] = pv;
					n_ch[2] = pv;
				end
				n_left = (left_q != '0) ? left_q - COUNT_W'(1) : left_q;
				n_rv = 1'b1;
				n_rk = KIND_PIXEL;
				n_re = ERR_NONE;
				n_rlast = (n_left == '0);
				if (n_left == '0) n_phase = PH_DONE;
			end
		end
		if (anum_end && n_phase == PH_ASKIP) rehandle = 1'b1;

		// Errors replace anything found earlier and halt the parser
		if (err) begin
			n_rv = 1'b1;
			n_rk = KIND_ERROR;
			n_re = ecode;
			n_rlast = 1'b0;
			n_phase = PH_HALT;
		end
	end

	logic        commit;
	logic        flush_now;
	logic        eos_err;
	logic [2:0]  eos_code;
	logic        fin_go;
	logic        clear_parse;
	logic [15:0] dv;
	logic [23:0] dprod;
	logic [16:0] trial;

	assign commit    = (seq_q == S_PROC);
	assign flush_now = eos_q && !flush_q && !n_rv && (n_phase == PH_HNUM || n_phase == PH_ANUM);
	assign eos_err   = eos_q && !rehandle && !flush_now && !(n_rv && n_rk == KIND_ERROR)
		&& n_phase != PH_DONE;
	assign eos_code  = (n_phase <= PH_MAGIC1) ? ERR_MAGIC :
		((n_phase <= PH_HNUM) ? ERR_HEADER : ERR_PREMATURE);
	assign fin_go      = (seq_q == S_FIN) && (!out_v_q || results.ready);
	assign clear_parse = fin_go && eos_q;

	assign dv    = ch_q[dch_q];
	assign dprod = {dv, 8'd0} - {8'd0, dv};
	assign trial = {rem_q, dd_q[7]};

	// Hold and advance the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC0;
			fmt_q <= '0;
			width_q <= '0;
			height_q <= '0;
			maxval_q <= '0;
			acc_q <= '0;
			hbyte_q <= '0;
			ci_q <= '0;
			ch_q <= '{default: '0};
			left_q <= '0;
			fsel_q <= '0;
			neg_q <= 1'b0;
			dseen_q <= 1'b0;
			hpend_q <= 1'b0;
		end else if (clear_parse) begin
			phase_q <= PH_MAGIC0;
			fmt_q <= '0;
			width_q <= '0;
			height_q <= '0;
			maxval_q <= '0;
			acc_q <= '0;
			hbyte_q <= '0;
			ci_q <= '0;
			ch_q <= '{default: '0};
			left_q <= '0;
			fsel_q <= '0;
			neg_q <= 1'b0;
			dseen_q <= 1'b0;
			hpend_q <= 1'b0;
		end else if (commit) begin
			phase_q <= n_phase;
			fmt_q <= n_fmt;
			width_q <= n_width;
			height_q <= n_height;
			maxval_q <= n_maxval;
			acc_q <= n_acc;
			hbyte_q <= n_hbyte;
			ci_q <= n_ci;
			ch_q <= n_ch;
			left_q <= n_left;
			fsel_q <= n_fsel;
			neg_q <= n_neg;
			dseen_q <= n_dseen;
			hpend_q <= n_hpend;
		end
	end

	// Sequence parse passes, the divider and the output hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			cb_q <= '0;
			eos_q <= 1'b0;
			flush_q <= 1'b0;
			res_v_q <= 1'b0;
			res_kind_q <= KIND_HEADER;
			res_err_q <= ERR_NONE;
			res_last_q <= 1'b0;
			dch_q <= '0;
			dcnt_q <= '0;
			rem_q <= '0;
			dd_q <= '0;
			quo_q <= '0;
			s8_q <= '{default: '0};
			out_v_q <= 1'b0;
		end else begin
			// Raise the output word on hand-off, drop it once taken
			if (fin_go && res_v_q) out_v_q <= 1'b1;
			else if (results.ready) out_v_q <= 1'b0;
			unique case (seq_q)
				S_IDLE: begin
					if (bytes.valid) begin
						cb_q <= bytes.data_byte;
						eos_q <= bytes.end_of_stream;
						flush_q <= 1'b0;
						res_v_q <= 1'b0;
						seq_q <= S_PROC;
					end
				end
				S_PROC: begin
					if (eos_err) begin
						res_v_q <= 1'b1;
						res_kind_q <= KIND_ERROR;
						res_err_q <= eos_code;
						res_last_q <= 1'b0;
					end else begin
						res_v_q <= n_rv;
						res_kind_q <= n_rk;
						res_err_q <= n_re;
						res_last_q <= n_rlast;
					end
					if (rehandle) begin
						seq_q <= S_PROC;
					end else if (flush_now) begin
						cb_q <= CH_SPACE;
						flush_q <= 1'b1;
					end else if (eos_err) begin
						seq_q <= S_FIN;
					end else if (n_rv && n_rk == KIND_PIXEL) begin
						dch_q <= 2'd0;
						seq_q <= S_DIV_LD;
					end else begin
						seq_q <= S_FIN;
					end
				end
				S_DIV_LD: begin
					if (dv >= maxval_q) begin
						s8_q[dch_q] <= 8'd255;
						if (dch_q == 2'd2) seq_q <= S_FIN;
						dch_q <= dch_q + 2'd1;
					end else begin
						rem_q <= dprod[23:8];
						dd_q <= dprod[7:0];
						dcnt_q <= '0;
						quo_q <= '0;
						seq_q <= S_DIV_IT;
					end
				end
				S_DIV_IT: begin
					dd_q <= {dd_q[6:0], 1'b0};
					if (trial >= {1'b0, maxval_q}) begin
						rem_q <= 16'(trial - {1'b0, maxval_q});
						quo_q <= {quo_q[6:0], 1'b1};
					end else begin
						rem_q <= trial[15:0];
						quo_q <= {quo_q[6:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						s8_q[dch_q] <= {quo_q[6:0], (trial >= {1'b0, maxval_q})};
						dch_q <= dch_q + 2'd1;
						seq_q <= (dch_q == 2'd2) ? S_FIN : S_DIV_LD;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						res_v_q <= 1'b0;
						seq_q <= S_IDLE;
					end
				end
				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

	// Load the output word; fields foreign to the result kind are zero
	always_ff @(posedge clk) begin
		if (fin_go && res_v_q) begin
			o_kind_q <= res_kind_q;
			o_err_q <= (res_kind_q == KIND_ERROR) ? res_err_q : ERR_NONE;
			o_last_q <= (res_kind_q == KIND_PIXEL) && res_last_q;
			o_w_q <= (res_kind_q == KIND_HEADER) ? width_q : '0;
			o_h_q <= (res_kind_q == KIND_HEADER) ? height_q : '0;
			o_max_q <= (res_kind_q == KIND_HEADER) ? maxval_q : '0;
			for (int i = 0; i < 3; i++) begin
				o_s8_q[i] <= (res_kind_q == KIND_PIXEL) ? s8_q[i] : '0;
				o_full_q[i] <= (res_kind_q == KIND_PIXEL) ? ch_q[i] : '0;
			end
		end
	end

	assign bytes.ready        = (seq_q == S_IDLE);
	assign results.valid      = out_v_q;
	assign results.kind       = o_kind_q;
	assign results.fault_code = o_err_q;
	assign results.red8       = o_s8_q[0];
	assign results.green8     = o_s8_q[1];
	assign results.blue8      = o_s8_q[2];
	assign results.red_full   = o_full_q[0];
	assign results.green_full = o_full_q[1];
	assign results.blue_full  = o_full_q[2];
	assign results.image_width  = o_w_q;
	assign results.image_height = o_h_q;
	assign results.sample_max   = o_max_q;
	assign results.last_pixel   = o_last_q;

`ifndef SYNTHESIS
	// The divider remainder stays below maxval while iterating
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_DIV_IT) |-> (rem_q < maxval_q))
		else $error("divider remainder not below maxval");

	// The divider only runs for a pending pixel
	a_div_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_DIV_LD || seq_q == S_DIV_IT) |-> (res_v_q && res_kind_q == KIND_PIXEL))
		else $error("divider active without a pixel result");

	// The channel index never passes the last channel
	a_ci_range: assert property (@(posedge clk) disable iff (!arst_n)
		ci_q != 2'd3)
		else $error("channel index out of range");

	// The word after end of stream starts again at the magic
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && eos_q) |=> (phase_q == PH_MAGIC0 && left_q == '0))
		else $error("parser not reset after end of stream");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_pnm_stream_decoder.sv =====
// Testbench for the PNM stream decoder: directed and random files checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_pnm_stream_decoder;
	import pnm_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  fault_code;
		logic [7:0]  red8;
		logic [7:0]  green8;
		logic [7:0]  blue8;
		logic [15:0] red_full;
		logic [15:0] green_full;
		logic [15:0] blue_full;
		logic [14:0] image_width;
		logic [14:0] image_height;
		logic [15:0] sample_max;
		logic        last_pixel;
	} decode_result_t;

	typedef enum logic [3:0] {
		ST_MAGIC0, ST_MAGIC1, ST_HSKIP, ST_HCOMMENT, ST_HNUM,
		ST_ASKIP, ST_ANUM, ST_BDATA, ST_DONE, ST_HALT
	} parse_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   failed = 1'b0;
	bit   idle_en = 1'b1;
	int   cycle_count = 0;
	int   stall_left = 0;

	pnm_byte_if   bytes ();
	pnm_result_if results ();

	pnm_stream_decoder DUT (.clk(clk), .arst_n(arst_n), .bytes(bytes), .results(results));

	always #5 clk = ~clk;

	// Abort on runaway
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("tb_pnm_stream_decoder NOT OK");
			$finish;
		end
	end

	// Predictor state
	parse_state_t st;
	logic [1:0]  fmt;
	logic [16:0] wdt, hgt, mval, accum;
	logic [7:0]  hi_hold;
	int unsigned chan_idx;
	logic [15:0] chan_val [3];
	logic [COUNT_W-1:0] px_left;
	int unsigned field_idx;
	bit neg, got_digit, hi_pending;
	bit have_res;
	decode_result_t res;
	decode_result_t expected_results [$];

	function automatic bit is_space(logic [7:0] b);
		return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic bit is_num(logic [7:0] b);
		return b >= 8'd48 && b <= 8'd57;
	endfunction

	function automatic logic [16:0] add_digit(logic [16:0] a, logic [7:0] b);
		logic [31:0] v;
		v = 32'(a) * 10 + 32'(b - 8'd48);
		return v > 32'(NUM_SAT) ? NUM_SAT : v[16:0];
	endfunction

	function automatic logic [7:0] to8(logic [15:0] v, logic [16:0] m);
		logic [31:0] q;
		q = (32'(v) * 255) / (m == 0 ? 32'd1 : 32'(m));
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	task automatic clear_decoder();
		st = ST_MAGIC0; fmt = 0; wdt = 0; hgt = 0; mval = 0; accum = 0; hi_hold = 0;
		chan_idx = 0; chan_val = '{default: 16'd0}; px_left = 0; field_idx = 0;
		neg = 0; got_digit = 0; hi_pending = 0;
	endtask

	function automatic void raise_error(logic [2:0] code);
		res = '0; res.kind = KIND_ERROR; res.fault_code = code;
		have_res = 1; st = ST_HALT;
	endfunction

	function automatic void take_sample(logic [15:0] v);
		int unsigned need;
		need = (fmt == 1 || fmt == 3) ? 3 : 1;
		chan_val[chan_idx > 2 ? 2 : chan_idx] = v;
		chan_idx++;
		if (chan_idx < need) return;
		chan_idx = 0;
		if (need == 1) begin
			chan_val[1] = chan_val[0]; chan_val[2] = chan_val[0];
		end
		if (px_left > 0) px_left--;
		res = '0; res.kind = KIND_PIXEL;
		res.red_full = chan_val[0]; res.green_full = chan_val[1]; res.blue_full = chan_val[2];
		res.red8 = to8(chan_val[0], mval); res.green8 = to8(chan_val[1], mval);
		res.blue8 = to8(chan_val[2], mval);
		res.last_pixel = px_left == 0;
		have_res = 1;
		if (px_left == 0) st = ST_DONE;
	endfunction

	// Close a header number; return 1 when the byte is parsed again
	function automatic bit close_header_num(logic [7:0] b);
		logic [16:0] v;
		v = accum; accum = 0;
		if (field_idx < 2) begin
			if (v == 0 || v > DIM_LIM) begin
				raise_error(ERR_HEADER); return 0;
			end
			if (field_idx == 0) wdt = v; else hgt = v;
			field_idx++; st = ST_HSKIP;
			return 1;
		end
		if (v == 0 || v > MAXVAL_LIM) begin
			raise_error(ERR_HEADER); return 0;
		end
		mval = v; px_left = COUNT_W'(wdt) * COUNT_W'(hgt); chan_idx = 0; hi_pending = 0;
		if (fmt < 2) begin
			if (!is_space(b)) begin
				raise_error(ERR_HEADER); return 0;
			end
			st = ST_ASKIP;
		end else st = ST_BDATA;
		res = '0; res.kind = KIND_HEADER;
		res.image_width = wdt[14:0]; res.image_height = hgt[14:0]; res.sample_max = mval[15:0];
		have_res = 1;
		return 0;
	endfunction

	function automatic bit parse_byte(logic [7:0] b);
		logic [16:0] v;
		case (st)
			ST_MAGIC0: if (b == CH_P) st = ST_MAGIC1; else raise_error(ERR_MAGIC);
			ST_MAGIC1: begin
				if (b == CH_2) fmt = 0;
				else if (b == CH_3) fmt = 1;
				else if (b == CH_5) fmt = 2;
				else if (b == CH_6) fmt = 3;
				else begin
					raise_error(ERR_MAGIC); return 0;
				end
				field_idx = 0; st = ST_HSKIP;
			end
			ST_HSKIP: begin
				if (is_space(b)) return 0;
				if (b == CH_HASH) st = ST_HCOMMENT;
				else if (is_num(b)) begin
					accum = 17'(b - 8'd48); st = ST_HNUM;
				end else raise_error(ERR_HEADER);
			end
			ST_HCOMMENT: if (b == CH_LF) st = ST_HSKIP;
			ST_HNUM: begin
				if (is_num(b)) begin
					accum = add_digit(accum, b); return 0;
				end
				return close_header_num(b);
			end
			ST_ASKIP: begin
				if (is_space(b)) return 0;
				if (is_num(b)) begin
					accum = 17'(b - 8'd48); neg = 0; got_digit = 1; st = ST_ANUM;
				end else if (b == CH_MINUS || b == CH_PLUS) begin
					accum = 0; neg = b == CH_MINUS; got_digit = 0; st = ST_ANUM;
				end else raise_error(ERR_SAMPLE);
			end
			ST_ANUM: begin
				if (is_num(b)) begin
					accum = add_digit(accum, b); got_digit = 1; return 0;
				end
				if (!got_digit) begin
					raise_error(ERR_SAMPLE); return 0;
				end
				v = neg ? 17'd0 : accum;
				if (v > mval) v = mval;
				accum = 0; st = ST_ASKIP;
				take_sample(v[15:0]);
				return st == ST_ASKIP;
			end
			ST_BDATA: begin
				if (mval > 255) begin
					if (!hi_pending) begin
						hi_hold = b; hi_pending = 1;
					end else begin
						hi_pending = 0; take_sample({hi_hold, b});
					end
				end else take_sample({8'd0, b});
			end
			default: ;
		endcase
		return 0;
	endfunction

	task automatic predict_byte(logic [7:0] b, bit eos);
		have_res = 0;
		if (parse_byte(b)) void'(parse_byte(b));
		if (eos) begin
			if (!have_res && (st == ST_HNUM || st == ST_ANUM))
				if (parse_byte(CH_SPACE)) void'(parse_byte(CH_SPACE));
			if (!(have_res && res.kind == KIND_ERROR) && st != ST_DONE) begin
				if (st <= ST_MAGIC1) raise_error(ERR_MAGIC);
				else if (st <= ST_HNUM) raise_error(ERR_HEADER);
				else raise_error(ERR_PREMATURE);
			end
			clear_decoder();
		end
		if (have_res) expected_results = {expected_results, res};
	endtask

	// Send one word, predicting at acceptance; starts and ends at a falling edge
	task automatic send_byte(logic [7:0] b, bit eos);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			bytes.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		bytes.valid <= 1'b1; bytes.data_byte <= b; bytes.end_of_stream <= eos;
		@(posedge clk);
		while (!bytes.ready) @(posedge clk);
		predict_byte(b, eos);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit eos_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eos_at_end && i == s.len() - 1);
	endtask

	// Output stall generator: random bursts of low ready while idle_en is set
	always @(negedge clk) begin
		if (!idle_en) begin
			results.ready <= 1'b1;
		end else if (stall_left > 0) begin
			results.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			results.ready <= 1'b0;
			stall_left = $urandom_range(0, 7);
		end else begin
			results.ready <= 1'b1;
		end
	end

	// Check each accepted result word
	always @(posedge clk) begin
		decode_result_t got, exp_r;
		if (arst_n && results.valid && results.ready) begin
			got = '{results.kind, results.fault_code, results.red8, results.green8,
				results.blue8, results.red_full, results.green_full, results.blue_full,
				results.image_width, results.image_height, results.sample_max,
				results.last_pixel};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failed = 1;
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
					failed = 1;
				end
			end
		end
	end

	// Drop the input and wait until every expected word has come
	task automatic wait_drained();
		bytes.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic string num_text(int unsigned v);
		return $sformatf("%0d", v);
	endfunction

	function automatic string space_text();
		case ($urandom_range(0, 5))
			0: return "\n";
			1: return "\t";
			2: return " \r\n";
			3: return "\v\f ";
			default: return " ";
		endcase
	endfunction

	// Random well-formed file, sometimes broken or truncated
	task automatic send_random_file();
		int unsigned f, w, h, m, n, s, bad;
		string hdr;
		f = $urandom_range(0, 3);
		w = $urandom_range(1, 3); h = $urandom_range(1, 3);
		case ($urandom_range(0, 4))
			0: m = 255;
			1: m = 65535;
			2: m = $urandom_range(256, 65535);
			3: m = 1;
			default: m = $urandom_range(1, 255);
		endcase
		bad = $urandom_range(0, 9);
		hdr = {"P", string'(8'(f == 0 ? CH_2 : f == 1 ? CH_3 : f == 2 ? CH_5 : CH_6)),
			space_text()};
		if ($urandom_range(0, 2) == 0) hdr = {hdr, "# note\n"};
		hdr = {hdr, num_text(w), space_text(), num_text(h), space_text(), num_text(m)};
		if (bad == 0) begin
			hdr[$urandom_range(0, hdr.len() - 1)] = 8'($urandom);
		end
		send_text(hdr, 0);
		n = w * h * ((f == 1 || f == 3) ? 3 : 1);
		if (bad == 1) n = $urandom_range(0, n);
		if (f < 2) begin
			send_text(space_text(), 0);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: s = $urandom_range(0, 99999);
					1: s = 0;
					default: s = $urandom_range(0, m);
				endcase
				if ($urandom_range(0, 9) == 0) send_text("-", 0);
				else if ($urandom_range(0, 9) == 0) send_text("+", 0);
				send_text(num_text(s), 0);
				if (bad == 2 && i == n / 2) send_text("x", 0);
				if (i != n - 1 || $urandom_range(0, 1)) send_text(space_text(), 0);
			end
		end else begin
			send_byte(8'($urandom), 0);
			for (int i = 0; i < n; i++) begin
				if (m > 255) send_byte(8'($urandom), 0);
				send_byte(8'($urandom), 0);
			end
		end
		if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 0);
		send_byte(8'($urandom), 1);
	endtask

	task automatic test_magic_and_header();
		send_text("X", 1);
		send_text("P7", 1);
		send_text("P", 1);
		send_text("P2 0 1 1 ", 1);
		send_text("P2 16385 1 1 ", 1);
		send_text("P2 1 1 65536 ", 1);
		send_text("P2 1 99999999 0 ", 1);
		send_text("P2 -1 1 1 ", 1);
		send_text("P2 1 1 5x", 1);
		send_text("P2 1 1", 1);
	endtask

	task automatic test_ascii();
		send_text("P2 #c\n3 1 100\n-5 +250 7", 1);
		send_text("P3 16384 1 65535 65535 0 ", 1);
		send_text("P3 1 1 9 1 2 3 extra", 1);
		send_text("P2 2 1 9 - 1", 1);
		send_text("P2 2 1 9 1a", 1);
		send_text("P2 2 1 9\t\n1", 1);
	endtask

	task automatic test_binary();
		send_text("P5 2 1 255#", 0);
		send_byte(8'hFF, 0);
		send_byte(8'h00, 1);
		send_text("P6 1 1 1000 ", 0);
		send_byte(8'hFF, 0);
		send_byte(8'hFF, 0);
		send_byte(8'h00, 0);
		send_byte(8'h80, 0);
		send_byte(8'h01, 0);
		send_byte(8'h00, 1);
		send_text("P5 2 1 3 ", 0);
		send_byte(8'hFF, 1);
	endtask

	task automatic test_random_files();
		for (int i = 0; i < 3; i++) send_random_file();
		wait_drained();
		for (int i = 0; i < 2; i++) send_random_file();
		idle_en = 1'b0;
		for (int i = 0; i < 2; i++) send_random_file();
	endtask

	initial begin
		bytes.valid = 1'b0; bytes.data_byte = 8'd0; bytes.end_of_stream = 1'b0;
		results.ready = 1'b0;
		clear_decoder();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_magic_and_header();
		test_ascii();
		test_binary();
		test_random_files();
		wait_drained();
		if (!failed) $display("tb_pnm_stream_decoder OK");
		else $display("tb_pnm_stream_decoder NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pnm_pkg.sv
rtl/pnm_if.sv
rtl/pnm_stream_decoder.sv
dv/tb_pnm_stream_decoder.sv
